>>> src/sbrs_pkg.sv
package sbrs_pkg;

  localparam int unsigned LBA_W   = 48;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned REM_W   = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT  = 1'd1;

  // Request kinds
  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_FLUSH   = 2'd2;
  localparam logic [1:0] REQ_INVALID = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd1;
  localparam logic [1:0] STATUS_BAD    = 2'd2;

  // ATA opcodes and command header flags
  localparam logic [7:0] OP_READ       = 8'h25;
  localparam logic [7:0] OP_WRITE      = 8'h35;
  localparam logic [7:0] OP_FLUSH      = 8'hEA;
  localparam logic [6:0] FIS_LEN_FLAGS = 7'h05;
  localparam logic [6:0] WRITE_FLAG    = 7'h40;

  // Most results one request may cause
  localparam int unsigned RESULT_CAP = 64;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [LBA_W-1:0]   start_lba;
    logic [COUNT_W-1:0] sectors;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       ata_opcode;
    logic [LBA_W-1:0] cmd_lba;
    logic [3:0]       cmd_sectors;
    logic [12:0]      byte_count;
    logic [6:0]       header_flags;
    logic             prdt_length;
    logic [11:0]      prdt_byte_field;
    logic             last;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic load_single;
    logic load_chunk;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic absent;
    logic flush;
    logic bad;
    logic out_free;
    logic chunk_last;
  } ctrl_stat_t;

endpackage

>>> src/sbrs_ctrl.sv
module sbrs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sbrs_pkg::ctrl_stat_t   stat,
  output sbrs_pkg::ctrl_cmd_t    cmd
);
  import sbrs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    in_ready        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.out_free) begin
          if (stat.absent || stat.flush || stat.bad) begin
            cmd.load_single = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.load_chunk = 1'b1;
            state_nxt      = stat.chunk_last ? S_IDLE : S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_chunk = 1'b1;
          if (stat.chunk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/sbrs_datapath.sv
module sbrs_datapath #(
  parameter int unsigned SECTORS_PER_COMMAND = 8,
  parameter int unsigned SECTOR_BYTES        = 512,
  parameter int unsigned MAX_REQUEST_SECTORS = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbrs_pkg::req_t                      in_data,
  output sbrs_pkg::rsp_t                      out_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                cfg_we,
  input  logic [sbrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbrs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  sbrs_pkg::ctrl_cmd_t                 cmd,
  output sbrs_pkg::ctrl_stat_t                stat
);
  import sbrs_pkg::*;

  localparam int unsigned CHUNK_W = $clog2(SECTORS_PER_COMMAND + 1);
  localparam int unsigned BYTES_W = CHUNK_W + $clog2(SECTOR_BYTES + 1);
  localparam int unsigned LIMIT =
    (MAX_REQUEST_SECTORS < SECTORS_PER_COMMAND * RESULT_CAP) ?
    MAX_REQUEST_SECTORS : SECTORS_PER_COMMAND * RESULT_CAP;

  logic [LBA_W-1:0]   cap_r;
  logic               present_r;
  logic [1:0]         kind_r;
  logic [COUNT_W-1:0] count_r;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [LBA_W-1:0]   lba_r, lba_nxt;
  rsp_t               rsp_r, rsp_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               chunk_last;
  logic [CHUNK_W-1:0] chunk;
  logic [BYTES_W-1:0] bytes;
  logic               is_write;
  logic               bad;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= '0;
      present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: cap_r     <= cfg_wdata[LBA_W-1:0];
        CFG_PRESENT:  present_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Request checks against the captured request
  always_comb begin
    bad = (kind_r == REQ_INVALID) || (count_r == '0) ||
          (count_r > COUNT_W'(LIMIT)) || (lba_r >= cap_r) ||
          (LBA_W'(count_r) > (cap_r - lba_r));
  end

  // Chunk sizing
  always_comb begin
    chunk_last = (rem_r <= REM_W'(SECTORS_PER_COMMAND));
    chunk      = chunk_last ? rem_r[CHUNK_W-1:0] : CHUNK_W'(SECTORS_PER_COMMAND);
    bytes      = BYTES_W'(chunk) * BYTES_W'(SECTOR_BYTES);
    is_write   = (kind_r == REQ_WRITE);
  end

  always_comb begin
    rem_nxt       = rem_r;
    lba_nxt       = lba_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.capture) begin
      rem_nxt = in_data.sectors[REM_W-1:0];
      lba_nxt = in_data.start_lba;
    end
    if (cmd.load_single) begin
      rsp_nxt       = '0;
      rsp_nxt.last  = 1'b1;
      out_valid_nxt = 1'b1;
      priority if (!present_r) begin
        rsp_nxt.status = STATUS_ABSENT;
      end else if (kind_r == REQ_FLUSH) begin
        rsp_nxt.status       = STATUS_OK;
        rsp_nxt.ata_opcode   = OP_FLUSH;
        rsp_nxt.header_flags = FIS_LEN_FLAGS;
      end else begin
        rsp_nxt.status = STATUS_BAD;
      end
    end
    if (cmd.load_chunk) begin
      rsp_nxt.status          = STATUS_OK;
      rsp_nxt.ata_opcode      = is_write ? OP_WRITE : OP_READ;
      rsp_nxt.cmd_lba         = lba_r;
      rsp_nxt.cmd_sectors     = 4'(chunk);
      rsp_nxt.byte_count      = 13'(bytes);
      rsp_nxt.header_flags    = FIS_LEN_FLAGS | (is_write ? WRITE_FLAG : 7'h00);
      rsp_nxt.prdt_length     = (bytes != '0);
      rsp_nxt.prdt_byte_field = (bytes != '0) ? 12'(bytes - BYTES_W'(1)) : 12'h000;
      rsp_nxt.last            = chunk_last;
      rem_nxt                 = rem_r - REM_W'(chunk);
      lba_nxt                 = lba_r + LBA_W'(chunk);
      out_valid_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      lba_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      lba_r       <= lba_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
    if (cmd.capture) begin
      kind_r  <= in_data.req_type;
      count_r <= in_data.sectors;
    end
  end

  assign out_data        = rsp_r;
  assign out_valid       = out_valid_r;
  assign stat.absent     = !present_r;
  assign stat.flush      = (kind_r == REQ_FLUSH);
  assign stat.bad        = bad;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.chunk_last = chunk_last;

endmodule

>>> src/sata_block_request_splitter.sv
// Channel  Dir  Handshake             Payload
// in_      in   in_valid/in_ready     sbrs_pkg::req_t (req_type, start_lba, sectors)
// out_     out  out_valid/out_ready   sbrs_pkg::rsp_t (one command descriptor per beat)
// cfg_     in   cfg_we                cfg_index, cfg_wdata (capacity, device present)
//
// One request at a time: the accept state, then the check state, which also loads the
// first result, then one chunk descriptor per cycle from the chunk counter whenever
// the output register is free. A rejected request or a flush gives a single result.
// Reset is synchronous, active low; it clears the controller, the output valid, the
// chunk counter and both configuration registers.
// A low out_ready holds the chunk counter; the next request is taken while the final
// beat of the previous one still waits in the output register.
module sata_block_request_splitter #(
  parameter int unsigned SECTORS_PER_COMMAND = 8,
  parameter int unsigned SECTOR_BYTES        = 512,
  parameter int unsigned MAX_REQUEST_SECTORS = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sbrs_pkg::req_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sbrs_pkg::rsp_t                   out_data,
  input  logic                             cfg_we,
  input  logic [sbrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sbrs_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequence the request: accept, check, then step through the chunks
  sbrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the request, the configuration and the output beat register
  sbrs_datapath #(
    .SECTORS_PER_COMMAND (SECTORS_PER_COMMAND),
    .SECTOR_BYTES        (SECTOR_BYTES),
    .MAX_REQUEST_SECTORS (MAX_REQUEST_SECTORS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef NO_ASSERTIONS
  // An accepted request makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready right after a request beat");

  // While a non-final chunk waits, the request is still being split
  a_busy_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> !in_ready)
    else $error("new request taken before the final chunk was issued");

  // An error result always closes its request
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STATUS_OK)) |-> out_data.last)
    else $error("error status on a non-final beat");
`endif

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbrs_pkg::*;

  // Block geometry, kept at the defaults and handed to the instance below
  localparam int unsigned SECTORS_PER_CMD = 8;
  localparam int unsigned SECTOR_SIZE     = 512;
  localparam int unsigned MAX_REQ         = 512;
  // Largest accepted count: the request limit, clamped so it never needs more than
  // RESULT_CAP chunk commands
  localparam int unsigned REQ_LIMIT =
      (SECTORS_PER_CMD * RESULT_CAP < MAX_REQ) ? SECTORS_PER_CMD * RESULT_CAP : MAX_REQ;

  localparam logic [LBA_W-1:0] LBA_TOP = '1;

  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 40;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned END_CYCLES      = 20;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned CYCLE_LIMIT     = 1000000;

  // Single-beat answers that can be read straight off the spec
  localparam rsp_t RSP_ABSENT =
      '{STATUS_ABSENT, 8'h00, '0, 4'd0, 13'd0, 7'd0, 1'b0, 12'd0, 1'b1};
  localparam rsp_t RSP_BAD =
      '{STATUS_BAD, 8'h00, '0, 4'd0, 13'd0, 7'd0, 1'b0, 12'd0, 1'b1};
  localparam rsp_t RSP_FLUSH =
      '{STATUS_OK, OP_FLUSH, '0, 4'd0, 13'd0, FIS_LEN_FLAGS, 1'b0, 12'd0, 1'b1};

  // One row of the directed table: an optional drive setting to apply first, the
  // request, and the expected beat where it is a fixed single answer
  typedef struct {
    logic             wr_cfg;
    logic [LBA_W-1:0] cap;
    logic             present;
    req_t             req;
    logic             typed_ok;
    rsp_t             typed;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // Straight out of reset: no drive, so every kind is refused as absent
    '{1'b0, '0, 1'b0, '{REQ_READ, LBA_TOP, 12'hFFF}, 1'b1, RSP_ABSENT},
    '{1'b0, '0, 1'b0, '{REQ_FLUSH, 48'd0, 12'd0}, 1'b1, RSP_ABSENT},
    '{1'b0, '0, 1'b0, '{REQ_INVALID, 48'd5, 12'd3}, 1'b1, RSP_ABSENT},
    // 1000-sector drive: flush ignores its fields, then each rejection rule
    '{1'b1, 48'd1000, 1'b1, '{REQ_FLUSH, LBA_TOP, 12'hFFF}, 1'b1, RSP_FLUSH},
    '{1'b0, '0, 1'b0, '{REQ_INVALID, 48'd0, 12'd1}, 1'b1, RSP_BAD},
    '{1'b0, '0, 1'b0, '{REQ_READ, 48'd0, 12'd0}, 1'b1, RSP_BAD},
    '{1'b0, '0, 1'b0, '{REQ_WRITE, 48'd0, 12'd513}, 1'b1, RSP_BAD},
    '{1'b0, '0, 1'b0, '{REQ_READ, 48'd0, 12'hFFF}, 1'b1, RSP_BAD},
    '{1'b0, '0, 1'b0, '{REQ_READ, 48'd1000, 12'd1}, 1'b1, RSP_BAD},
    '{1'b0, '0, 1'b0, '{REQ_WRITE, 48'd999, 12'd2}, 1'b1, RSP_BAD},
    // Accepted requests: last sector, one full chunk, a chunk plus one, the
    // largest count ending exactly at capacity, an unaligned split
    '{1'b0, '0, 1'b0, '{REQ_READ, 48'd999, 12'd1}, 1'b0, '0},
    '{1'b0, '0, 1'b0, '{REQ_WRITE, 48'd0, 12'd8}, 1'b0, '0},
    '{1'b0, '0, 1'b0, '{REQ_READ, 48'd0, 12'd9}, 1'b0, '0},
    '{1'b0, '0, 1'b0, '{REQ_WRITE, 48'd488, 12'd512}, 1'b0, '0},
    '{1'b0, '0, 1'b0, '{REQ_READ, 48'd7, 12'd15}, 1'b0, '0},
    // Full 48-bit drive: top of the address space
    '{1'b1, LBA_TOP, 1'b1, '{REQ_READ, LBA_TOP - 48'd512, 12'd512}, 1'b0, '0},
    '{1'b0, '0, 1'b0, '{REQ_WRITE, LBA_TOP - 48'd1, 12'd1}, 1'b0, '0},
    '{1'b0, '0, 1'b0, '{REQ_READ, LBA_TOP, 12'd1}, 1'b1, RSP_BAD},
    '{1'b0, '0, 1'b0, '{REQ_WRITE, 48'h5555_5555_5555, 12'hAAA}, 1'b1, RSP_BAD},
    '{1'b0, '0, 1'b0, '{REQ_READ, 48'hAAAA_AAAA_AAAA, 12'h155}, 1'b0, '0},
    // Zero-capacity drive: nothing fits, flush still goes through
    '{1'b1, 48'd0, 1'b1, '{REQ_READ, 48'd0, 12'd1}, 1'b1, RSP_BAD},
    '{1'b0, '0, 1'b0, '{REQ_FLUSH, 48'd0, 12'd0}, 1'b1, RSP_FLUSH},
    // Drive pulled while capacity is maximal
    '{1'b1, LBA_TOP, 1'b0, '{REQ_WRITE, 48'd0, 12'd8}, 1'b1, RSP_ABSENT}
  };

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  req_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the drive settings and of the chunk loop registers
  logic [LBA_W-1:0] drive_cap     = '0;
  logic             drive_present = 1'b0;
  logic [REM_W-1:0] pend_sectors  = '0;
  logic [LBA_W-1:0] chunk_lba     = '0;

  rsp_t cmd_expect_q [$];

  int unsigned fail_count     = 0;
  int unsigned req_count      = 0;
  int unsigned beat_count     = 0;
  int unsigned reject_beats   = 0;
  int unsigned flush_beats    = 0;
  int unsigned settings_count = 0;
  int unsigned cycle_count    = 0;

  // Receiver pacing
  logic        long_hold_req = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned rx_mode_left  = 0;
  int unsigned rx_tick       = 0;
  rx_mode_t    rx_mode       = RX_OPEN;

  sata_block_request_splitter #(
    .SECTORS_PER_COMMAND(SECTORS_PER_CMD),
    .SECTOR_BYTES       (SECTOR_SIZE),
    .MAX_REQUEST_SECTORS(MAX_REQ)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the command beats one accepted request must produce, in order,
  // and queue them behind whatever is still outstanding
  task automatic split_request(input req_t r);
    rsp_t        c;
    logic [3:0]  chunk;
    logic [12:0] bytes;
    int          n;
    c = '0;
    c.last = 1'b1;
    n = 0;
    if (!drive_present) begin
      c.status = STATUS_ABSENT;
      cmd_expect_q.push_back(c);
    end else if (r.req_type == REQ_FLUSH) begin
      c.ata_opcode   = OP_FLUSH;
      c.header_flags = FIS_LEN_FLAGS;
      cmd_expect_q.push_back(c);
    end else if (r.req_type == REQ_INVALID || r.sectors == '0 ||
                 r.sectors > COUNT_W'(REQ_LIMIT) || r.start_lba >= drive_cap ||
                 LBA_W'(r.sectors) > drive_cap - r.start_lba) begin
      c.status = STATUS_BAD;
      cmd_expect_q.push_back(c);
    end else begin
      c.ata_opcode   = (r.req_type == REQ_WRITE) ? OP_WRITE : OP_READ;
      c.header_flags = FIS_LEN_FLAGS | ((r.req_type == REQ_WRITE) ? WRITE_FLAG : 7'h00);
      pend_sectors   = r.sectors[REM_W-1:0];
      chunk_lba      = r.start_lba;
      while (pend_sectors != '0 && n < RESULT_CAP) begin
        chunk = (pend_sectors > REM_W'(SECTORS_PER_CMD)) ? 4'(SECTORS_PER_CMD)
                                                         : 4'(pend_sectors);
        pend_sectors      = pend_sectors - REM_W'(chunk);
        bytes             = 13'(chunk * SECTOR_SIZE);
        c.cmd_lba         = chunk_lba;
        c.cmd_sectors     = chunk;
        c.byte_count      = bytes;
        c.prdt_length     = (bytes != '0);
        c.prdt_byte_field = c.prdt_length ? 12'(bytes - 13'd1) : 12'd0;
        c.last            = (pend_sectors == '0);
        cmd_expect_q.push_back(c);
        chunk_lba = chunk_lba + LBA_W'(chunk);
        n++;
      end
    end
  endtask

  // Offer one request and hold it until the block takes it. Valid is left high
  // on return so a back-to-back beat can follow in the same step.
  task automatic issue_request(input req_t r, input logic has_typed, input rsp_t typed);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    req_count++;
    if (has_typed) cmd_expect_q.push_back(typed);
    else split_request(r);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering and wait until every queued beat has come out, then give the
  // block time to settle back to idle
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Change the drive settings only with the block idle
  task automatic configure_drive(input logic [LBA_W-1:0] cap, input logic present);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_wdata <= CFG_DATA_W'(cap);
    @(posedge clk);
    cfg_index <= CFG_PRESENT;
    cfg_wdata <= CFG_DATA_W'(present);
    @(posedge clk);
    cfg_we        <= 1'b0;
    drive_cap     = cap;
    drive_present = present;
    settings_count++;
  endtask

  // Random request: mostly well-formed reads and writes that fit the drive,
  // with flushes, garbage kinds, off-the-end ranges and bad counts mixed in
  function automatic req_t draw_request();
    req_t        r;
    int unsigned pick;
    int unsigned size_pick;
    logic [11:0] n;
    logic [63:0] span;
    logic [63:0] roll;
    pick      = $urandom_range(0, 99);
    size_pick = $urandom_range(0, 99);
    roll      = {$urandom, $urandom};
    // Mostly short requests; a few reach the full limit
    if (size_pick < 85) n = 12'($urandom_range(1, 24));
    else if (size_pick < 97) n = 12'($urandom_range(25, 128));
    else n = 12'($urandom_range(129, REQ_LIMIT));
    r.req_type  = ($urandom_range(0, 1) != 0) ? REQ_WRITE : REQ_READ;
    r.start_lba = roll[LBA_W-1:0];
    r.sectors   = 12'($urandom);
    if (pick < 6) begin
      r.req_type = REQ_FLUSH;
    end else if (pick < 14) begin
      r.req_type = 2'($urandom);
    end else if (pick < 20) begin
      // Run one sector past the end of the drive
      r.sectors   = n;
      r.start_lba = drive_cap - LBA_W'(n) + LBA_W'(1);
    end else if (pick < 24) begin
      r.start_lba = '0;
      case ($urandom_range(0, 2))
        0:       r.sectors = '0;
        1:       r.sectors = 12'(REQ_LIMIT + 1);
        default: r.sectors = 12'($urandom_range(REQ_LIMIT + 1, 4095));
      endcase
    end else begin
      if (drive_cap < LBA_W'(n)) n = drive_cap[11:0];
      span        = 64'(drive_cap - LBA_W'(n));
      r.start_lba = LBA_W'(roll % (span + 64'd1));
      r.sectors   = n;
    end
    return r;
  endfunction

  task automatic compare_beat(input rsp_t got, input rsp_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.ata_opcode !== want.ata_opcode) begin
      $error("ata_opcode: expected %0h, got %0h", want.ata_opcode, got.ata_opcode);
      fail_count++;
    end
    if (got.cmd_lba !== want.cmd_lba) begin
      $error("cmd_lba: expected %0h, got %0h", want.cmd_lba, got.cmd_lba);
      fail_count++;
    end
    if (got.cmd_sectors !== want.cmd_sectors) begin
      $error("cmd_sectors: expected %0d, got %0d", want.cmd_sectors, got.cmd_sectors);
      fail_count++;
    end
    if (got.byte_count !== want.byte_count) begin
      $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
      fail_count++;
    end
    if (got.header_flags !== want.header_flags) begin
      $error("header_flags: expected %0h, got %0h", want.header_flags, got.header_flags);
      fail_count++;
    end
    if (got.prdt_length !== want.prdt_length) begin
      $error("prdt_length: expected %0d, got %0d", want.prdt_length, got.prdt_length);
      fail_count++;
    end
    if (got.prdt_byte_field !== want.prdt_byte_field) begin
      $error("prdt_byte_field: expected %0h, got %0h",
             want.prdt_byte_field, got.prdt_byte_field);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  // Score every beat the block hands over against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beat_count++;
      if (out_data.status != STATUS_OK) reject_beats++;
      if (out_data.ata_opcode == OP_FLUSH) flush_beats++;
      if (cmd_expect_q.size() == 0) begin
        $error("beat with nothing expected: status %0d opcode %0h lba %0h",
               out_data.status, out_data.ata_opcode, out_data.cmd_lba);
        fail_count++;
      end else begin
        compare_beat(out_data, cmd_expect_q.pop_front());
      end
    end
  end

  // Receiver: switch between pacing patterns every so often, and on request
  // hold ready low for a long stretch so the block backs up into its input
  always @(posedge clk) begin
    rx_tick++;
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= ($urandom_range(0, 1) != 0);
        RX_QUARTER: out_ready <= (rx_tick % 4 == 0);
        default:    out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: give up if the run stalls
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [LBA_W-1:0] next_cap;
    logic             next_present;
    int unsigned      burst_left;

    // Hold reset, then release it once for good
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the table, applying each drive setting as it comes
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_cfg) configure_drive(dir_tab[i].cap, dir_tab[i].present);
      issue_request(dir_tab[i].req, dir_tab[i].typed_ok, dir_tab[i].typed);
    end

    // Random part: one drive setting per phase, the sender working in bursts
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      next_present = 1'b1;
      case (p)
        0:       next_cap = LBA_W'($urandom_range(1, 64));
        1:       next_cap = LBA_W'($urandom_range(512, 20000));
        2, 6:    next_cap = LBA_TOP;
        4: begin
          next_cap     = LBA_W'({$urandom, $urandom});
          next_present = 1'b0;
        end
        5:       next_cap = LBA_W'($urandom_range(1, 16));
        default: next_cap = LBA_W'({$urandom, $urandom});
      endcase
      configure_drive(next_cap, next_present);
      burst_left = $urandom_range(1, 30);
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Phase 2 stalls the receiver for a long while and keeps offering beats
        // back to back, so the block fills and drops in_ready
        if (p == 2 && i == 0) long_hold_req = 1'b1;
        // Mid-phase, let everything drain without touching the settings
        if (p == 5 && i == ITEMS_PER_PHASE / 2) wait_for_drain();
        issue_request(draw_request(), 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          if (p != 2) pause_sender($urandom_range(1, 12));
          burst_left = $urandom_range(1, 30);
        end
      end
    end

    // Drain, then give any stray beat time to show up
    wait_for_drain();
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d drive settings; checked %0d command beats",
             req_count, settings_count, beat_count);
    $display("including %0d rejections and %0d flushes.", reject_beats, flush_beats);
    if (fail_count == 0 && cmd_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
